[rtl/wtgt_pkg.sv]
// ----------------------------------------------------------------------------
// wtgt_pkg: shared definitions of the wind triangle ground track core
// Register indexes, wind modes, beat payload types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package wtgt_pkg;

	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int COUNT_BITS_DEF   = 16;

	// Number of entries in the arctangent table.
	localparam int ATAN_LEN = 24;

	// CORDIC x/y datapath width: Q2.30 values plus headroom for the gain.
	localparam int CW = 34;

	localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
	localparam logic [30:0]          Q30_ONE      = 31'h4000_0000;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_WIND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIND_DIR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AIRSPEED  = 3'd4;

	localparam logic [1:0] MODE_CONST = 2'd0;
	localparam logic [1:0] MODE_SAW   = 2'd1;
	localparam logic [1:0] MODE_ALT   = 2'd2;
	// The spare mode code behaves as constant wind.
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	localparam logic [15:0] AIRSPEED_RESET = 16'd256;

	typedef struct packed {
		logic        [15:0] heading_in;
		logic signed [15:0] gps_offset;
	} in_t;

	typedef struct packed {
		logic        [15:0] heading_out;
		logic signed [23:0] ground_distance;
		logic        [15:0] wind_speed_now;
		logic               ratio_clipped;
	} out_t;

	// atan(2^-i) as a fraction of a turn, scaled by 2^32.
	function automatic logic [31:0] atan_turn32(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// Table entry rounded to a binary angle of ab bits.
	function automatic logic [31:0] atan_step(input logic [4:0] i, input int ab);
		logic [32:0] t;
		t = {1'b0, atan_turn32(i)} + (33'd1 << (31 - ab));
		return 32'(t >> (32 - ab));
	endfunction

endpackage

[rtl/wind_triangle_ground_track_core.sv]
// ----------------------------------------------------------------------------
// wind_triangle_ground_track_core
// Wind corrected heading and ground distance for one simulation tick per beat.
// ----------------------------------------------------------------------------
// One input beat is one tick. The core takes a beat only when idle and works on
// it alone; it returns one result beat per tick. The work is done by one shared
// CORDIC stage run twice (sine/cosine, then arcsine angle), one restoring
// divider producing a bit per cycle (for the crosswind ratio and the sawtooth
// wind), a square root producing a bit per cycle and one shared 35x17
// multiplier. The result sits in an output register, so the next tick can be
// accepted while it waits.
module wind_triangle_ground_track_core
	import wtgt_pkg::*;
#(
	parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data
);

	localparam int STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int ZW    = ANGLE_BITS + 2;
	localparam int ASH   = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 16 - ANGLE_BITS;
	localparam int WRND  = (ANGLE_BITS > 16) ? (1 << (ANGLE_BITS - 17)) : 0;
	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	localparam logic signed [ZW-1:0] QUARTER = {{(ZW-1){1'b0}}, 1'b1} << (ANGLE_BITS - 2);
	localparam logic signed [ZW-1:0] HALF    = {{(ZW-1){1'b0}}, 1'b1} << (ANGLE_BITS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_WIND, S_WDIV0, S_DIV, S_ANGLE, S_CORD, S_NUM, S_RDIV0,
		S_MSQ_H, S_MSQ_L, S_SQ0, S_SQ, S_GS1, S_GS2, S_FIN
	} state_t;

	state_t state_q;

	// configuration and tick state
	logic [15:0]           base_q, wdir_q, period_q, tas_q;
	logic [1:0]            mode_q;
	logic [COUNT_BITS-1:0] tick_q;
	logic                  odd_q;
	out_t                  out_q;
	logic                  out_valid_q;

	// datapath
	logic        [15:0]    heading_q, wind_q, dd_q, rem_q;
	logic signed [15:0]    gps_q;
	logic        [30:0]    low_q, quo_q, mag_q, q_q;
	logic        [5:0]     cnt_q, lim_q;
	logic                  div_ratio_q, vec_q, neg_q, neg_num_q, clip_q;
	logic signed [CW-1:0]  cx_q, cy_q, s_q, c_q;
	logic signed [ZW-1:0]  cz_q, wca_q;
	logic        [60:0]    sv_q, sr_q, sb_q;
	logic signed [51:0]    mul_q;
	logic signed [61:0]    acc_q;

	logic in_acc, out_free, fin_load, it_last;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign fin_load = (state_q == S_FIN) && out_free;
	assign it_last  = (cnt_q == lim_q);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic [15:0] tas_eff;
	assign tas_eff = (tas_q == 16'd0) ? 16'd1 : tas_q;

	// shared multiplier
	logic signed [34:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [51:0] mul_p;
	logic               mul_en;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (state_q)
			S_WIND: begin
				mul_a = 35'(tick_q);
				mul_b = {1'b0, base_q};
			end
			S_NUM: begin
				mul_a = {s_q[CW-1], s_q};
				mul_b = {1'b0, wind_q};
			end
			S_MSQ_H: begin
				mul_a = 35'(mag_q);
				mul_b = {2'b00, mag_q[30:16]};
			end
			S_MSQ_L: begin
				mul_a = 35'(mag_q);
				mul_b = {1'b0, mag_q[15:0]};
			end
			S_GS1: begin
				mul_a = 35'(q_q);
				mul_b = {1'b0, tas_eff};
			end
			S_GS2: begin
				mul_a = {c_q[CW-1], c_q};
				mul_b = {1'b0, wind_q};
			end
			default: mul_en = 1'b0;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// heading minus wind direction, as a signed internal angle folded to
	// the right half plane
	logic [15:0]          diff;
	logic [39:0]          a_ext, a_sh;
	logic signed [ZW-1:0] a_ang, a_fold;
	logic                 a_neg;

	always_comb begin
		diff  = heading_q - wdir_q;
		a_ext = {24'd0, diff};
		a_sh  = (ANGLE_BITS >= 16) ? (a_ext << ASH) : (a_ext >> ASH);
		a_ang = {{2{a_sh[ANGLE_BITS-1]}}, a_sh[ANGLE_BITS-1:0]};
		a_fold = a_ang;
		a_neg  = 1'b0;
		if (a_ang > QUARTER) begin
			a_fold = a_ang - HALF;
			a_neg  = 1'b1;
		end else if (a_ang < -QUARTER) begin
			a_fold = a_ang + HALF;
			a_neg  = 1'b1;
		end
	end

	// CORDIC stage
	logic signed [CW-1:0] xs, ys, x_n, y_n;
	logic signed [ZW-1:0] at, z_n;
	logic                 cdir;

	always_comb begin
		xs   = cx_q >>> cnt_q[4:0];
		ys   = cy_q >>> cnt_q[4:0];
		at   = ZW'(atan_step(cnt_q[4:0], ANGLE_BITS));
		cdir = vec_q ? cy_q[CW-1] : !cz_q[ZW-1];
		if (cdir) begin
			x_n = cx_q - ys;
			y_n = cy_q + xs;
			z_n = cz_q - at;
		end else begin
			x_n = cx_q + ys;
			y_n = cy_q - xs;
			z_n = cz_q + at;
		end
	end

	// restoring divider step
	logic [16:0] rem2, rem_n;
	logic        dge;
	logic [30:0] quo_n;

	always_comb begin
		rem2  = {rem_q, low_q[30]};
		dge   = rem2 >= {1'b0, dd_q};
		rem_n = dge ? rem2 - {1'b0, dd_q} : rem2;
		quo_n = {quo_q[29:0], dge};
	end

	// square root step
	logic [61:0] rb;
	logic        sge;
	logic [60:0] sv_n, sr_n;

	always_comb begin
		rb   = {1'b0, sr_q} + {1'b0, sb_q};
		sge  = {1'b0, sv_q} >= rb;
		sv_n = sge ? 61'({1'b0, sv_q} - rb) : sv_q;
		sr_n = sge ? (sr_q >> 1) + sb_q : (sr_q >> 1);
	end

	// divider setup checks: a quotient too large for the register saturates
	logic [31:0]        w_hi;
	logic               w_sat;
	logic signed [51:0] absn;
	logic [16:0]        r_hi;
	logic               r_sat;

	always_comb begin
		w_hi  = mul_q[47:16];
		w_sat = w_hi >= {16'd0, dd_q};
		absn  = mul_q[51] ? -mul_q : mul_q;
		r_hi  = absn[47:31];
		r_sat = r_hi >= {1'b0, tas_eff};
	end

	logic signed [CW-1:0] r_val;
	assign r_val = neg_num_q ? -CW'(mag_q) : CW'(mag_q);

	logic signed [61:0] sq_tot, sq_v;
	assign sq_tot = acc_q + 62'(mul_q);
	assign sq_v   = (62'sd1 <<< 60) - sq_tot;

	// final assembly
	logic signed [47:0] w48, w_sc;
	logic signed [61:0] g, gr, dist_w;
	logic signed [23:0] dist_sat;
	logic [15:0]        wca16;

	always_comb begin
		w48   = 48'(wca_q);
		w_sc  = (ANGLE_BITS > 16) ? ((w48 + 48'(WRND)) >>> ASH) : (w48 <<< ASH);
		wca16 = w_sc[15:0];
		g     = acc_q + 62'(mul_q);
		gr    = (g + (62'sd1 <<< 29)) >>> 30;
		dist_w = gr + 62'(gps_q);
		if (dist_w > 62'sd8388607)
			dist_sat = 24'sh7FFFFF;
		else if (dist_w < -62'sd8388608)
			dist_sat = -24'sh800000;
		else
			dist_sat = dist_w[23:0];
	end

	// control, configuration, tick state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			wdir_q      <= '0;
			period_q    <= '0;
			mode_q      <= MODE_CONST;
			tas_q       <= AIRSPEED_RESET;
			tick_q      <= '0;
			odd_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_WIND: base_q   <= cfg_data;
					REG_WIND_DIR:  wdir_q   <= cfg_data;
					REG_PERIOD:    period_q <= cfg_data;
					REG_MODE:      mode_q   <= cfg_data[1:0];
					REG_AIRSPEED:  tas_q    <= cfg_data;
					default: ;
				endcase
			end

			if (fin_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (CMP_W'(tick_q) < CMP_W'(period_q)) begin
							tick_q <= tick_q + 1'b1;
						end else begin
							tick_q <= COUNT_BITS'(1);
							odd_q  <= !odd_q;
						end
						state_q <= S_WIND;
					end
				end
				S_WIND: begin
					if (mode_q == MODE_SAW && period_q >= 16'd2)
						state_q <= S_WDIV0;
					else
						state_q <= S_ANGLE;
				end
				S_WDIV0: state_q <= w_sat ? S_ANGLE : S_DIV;
				S_DIV: begin
					if (it_last)
						state_q <= div_ratio_q ? S_MSQ_H : S_ANGLE;
				end
				S_ANGLE: state_q <= S_CORD;
				S_CORD: begin
					if (it_last)
						state_q <= vec_q ? S_GS1 : S_NUM;
				end
				S_NUM:   state_q <= S_RDIV0;
				S_RDIV0: state_q <= r_sat ? S_MSQ_H : S_DIV;
				S_MSQ_H: state_q <= S_MSQ_L;
				S_MSQ_L: state_q <= S_SQ0;
				S_SQ0:   state_q <= S_SQ;
				S_SQ: begin
					if (it_last)
						state_q <= S_CORD;
				end
				S_GS1: state_q <= S_GS2;
				S_GS2: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						out_q.heading_out     <= heading_q + wca16;
						out_q.ground_distance <= dist_sat;
						out_q.wind_speed_now  <= wind_q;
						out_q.ratio_clipped   <= clip_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_en)
			mul_q <= mul_p;

		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					heading_q <= in_data.heading_in;
					gps_q     <= in_data.gps_offset;
					clip_q    <= 1'b0;
				end
			end
			S_WIND: begin
				dd_q <= period_q - 16'd1;
				case (mode_q)
					MODE_SAW: begin
						if (period_q < 16'd2)
							wind_q <= 16'hFFFF;
					end
					MODE_ALT: wind_q <= odd_q ? 16'd0 : base_q;
					default:  wind_q <= base_q;
				endcase
			end
			S_WDIV0: begin
				if (w_sat) begin
					wind_q <= 16'hFFFF;
				end else begin
					rem_q       <= mul_q[31:16];
					low_q       <= {mul_q[15:0], 15'd0};
					quo_q       <= '0;
					cnt_q       <= '0;
					lim_q       <= 6'd15;
					div_ratio_q <= 1'b0;
				end
			end
			S_DIV: begin
				rem_q <= rem_n[15:0];
				low_q <= {low_q[29:0], 1'b0};
				quo_q <= quo_n;
				cnt_q <= cnt_q + 6'd1;
				if (it_last) begin
					if (!div_ratio_q) begin
						wind_q <= quo_n[15:0];
					end else if (quo_n > Q30_ONE) begin
						mag_q  <= Q30_ONE;
						clip_q <= 1'b1;
					end else begin
						mag_q <= quo_n;
					end
				end
			end
			S_ANGLE: begin
				cx_q  <= CORDIC_START;
				cy_q  <= '0;
				cz_q  <= a_fold;
				neg_q <= a_neg;
				vec_q <= 1'b0;
				cnt_q <= '0;
				lim_q <= 6'(STEPS - 1);
			end
			S_CORD: begin
				cx_q  <= x_n;
				cy_q  <= y_n;
				cz_q  <= z_n;
				cnt_q <= cnt_q + 6'd1;
				if (it_last) begin
					if (vec_q) begin
						wca_q <= z_n;
					end else begin
						s_q <= neg_q ? -y_n : y_n;
						c_q <= neg_q ? -x_n : x_n;
					end
				end
			end
			S_RDIV0: begin
				neg_num_q <= mul_q[51];
				dd_q      <= tas_eff;
				if (r_sat) begin
					mag_q  <= Q30_ONE;
					clip_q <= 1'b1;
				end else begin
					rem_q       <= absn[46:31];
					low_q       <= absn[30:0];
					quo_q       <= '0;
					cnt_q       <= '0;
					lim_q       <= 6'd30;
					div_ratio_q <= 1'b1;
				end
			end
			S_MSQ_L: acc_q <= 62'(mul_q) <<< 16;
			S_SQ0: begin
				sv_q  <= sq_v[60:0];
				sr_q  <= '0;
				sb_q  <= 61'd1 << 60;
				cnt_q <= '0;
				lim_q <= 6'd30;
			end
			S_SQ: begin
				sv_q  <= sv_n;
				sr_q  <= sr_n;
				sb_q  <= sb_q >> 2;
				cnt_q <= cnt_q + 6'd1;
				if (it_last) begin
					// root done: start the arcsine on the vector (sqrt(1 - r^2), r)
					q_q   <= sr_n[30:0];
					cx_q  <= CW'(sr_n[30:0]);
					cy_q  <= r_val;
					cz_q  <= '0;
					vec_q <= 1'b1;
					cnt_q <= '0;
					lim_q <= 6'(STEPS - 1);
				end
			end
			S_GS2: acc_q <= 62'(mul_q);
			default: ;
		endcase
	end

	// The remainder of a running division always stays below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < dd_q)
		else $error("divider remainder not below divisor");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a tick is in progress");

	a_clip_mag: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MSQ_H && clip_q |-> mag_q == Q30_ONE)
		else $error("clipped ratio not held at one");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> out_valid && state_q == S_IDLE)
		else $error("finished tick did not reach the output register");

endmodule
